@@ hdl/la32_pkg.sv @@
// ----------------------------------------------------------------------------
// la32_pkg
// Shared types and constants of the LA32R integer decode/execute unit.
// ----------------------------------------------------------------------------
package la32_pkg;

  localparam int unsigned RegCountDefault = 32;
  localparam logic [31:0] ResetPcDefault = 32'h1C00_0000;

  typedef enum logic [2:0] {
    TRAP_NONE    = 3'd0,
    TRAP_SYSCALL = 3'd1,
    TRAP_BREAK   = 3'd2,
    TRAP_INVALID = 3'd3,
    TRAP_PRIV    = 3'd4
  } trap_e;

  typedef enum logic [2:0] {
    LK_B  = 3'd0,
    LK_H  = 3'd1,
    LK_W  = 3'd2,
    LK_BU = 3'd3,
    LK_HU = 3'd4
  } load_kind_e;

  // Front-to-back queue entry.
  typedef struct packed {
    logic        req_type;
    logic [31:0] instr;
    logic [31:0] load_data;
  } item_t;

  // Result payload.
  typedef struct packed {
    logic [31:0] trap_value;
    logic [2:0]  trap_code;
    logic [31:0] store_data;
    logic [1:0]  mem_size;
    logic [31:0] mem_address;
    logic        mem_write;
    logic        mem_valid;
    logic [31:0] next_pc;
  } result_t;

endpackage

@@ hdl/la32r_integer_decode_execute_unit.sv @@
// ----------------------------------------------------------------------------
// la32r_integer_decode_execute_unit
// LA32R integer decode/execute: input queue front end, multi-cycle back end.
// ----------------------------------------------------------------------------
// Steps per item after the queue pop: register file reads in RD1 and RD2,
// execute, output; multiply adds a multiply state, divide/modulo waits on the
// divider. The back end sequencer takes no new item until the last result is
// accepted; the register file has a single read port pair.
// Reset: pc loads 0x1C000000, queue and load state clear; register entries
// read as zero until first written (per-entry valid flags).
module la32r_integer_decode_execute_unit
  import la32_pkg::*;
#(
  parameter int unsigned RegCount = RegCountDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [31:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [63:0]  s_axis_tdata,   // instruction_word, load_data
  input  logic         s_axis_tuser,   // req_type
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [135:0] m_axis_tdata    // next_pc, mem_valid, mem_write, mem_address,
                                       // mem_size, store_data, trap_code, trap_value
);

  item_t   in_item, q_item;
  logic    q_valid, q_pop;
  result_t res;

  assign in_item.req_type  = s_axis_tuser;
  assign in_item.instr     = s_axis_tdata[31:0];
  assign in_item.load_data = s_axis_tdata[63:32];

  la32_front u_front (
    .clk_i, .rst_ni, .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .in_item_i(in_item), .q_valid_o(q_valid), .q_pop_i(q_pop), .q_item_o(q_item)
  );

  la32_back #(.RegCount(RegCount)) u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .q_valid_i(q_valid), .q_pop_o(q_pop),
    .q_item_i(q_item), .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready),
    .res_o(res)
  );

  assign m_axis_tdata = {1'b0, res.trap_value, res.trap_code, res.store_data,
                         res.mem_size, res.mem_address, res.mem_write,
                         res.mem_valid, res.next_pc};

  a_no_pop_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !q_pop) else $error("queue popped during output");
  a_mem_write_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[33]) |-> m_axis_tdata[32])
    else $error("write without valid");
  a_pop_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid) else $error("pop from empty queue");

endmodule

@@ hdl/la32_ram.sv @@
// ----------------------------------------------------------------------------
// la32_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module la32_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ hdl/la32_front.sv @@
// ----------------------------------------------------------------------------
// la32_front
// Input side: accepts items into a two-entry queue toward the execute back end.
// ----------------------------------------------------------------------------
module la32_front
  import la32_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t in_item_i,
  output logic  q_valid_o,
  input  logic  q_pop_i,
  output item_t q_item_o
);

  item_t      ent_q [2];
  logic       rd_ptr_q, wr_ptr_q;
  logic [1:0] cnt_q;
  logic       push;

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = ent_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= 1'b0;
      wr_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (q_pop_i) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_ptr_q] <= in_item_i;
    end
  end

endmodule

@@ hdl/la32_div.sv @@
// ----------------------------------------------------------------------------
// la32_div
// Radix-2 restoring divider, unsigned magnitudes, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module la32_div
  import la32_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [31:0] quot_o,
  output logic [31:0] rem_o
);

  logic [31:0] quot_q, rem_q, dvs_q;
  logic [5:0]  cnt_q;
  logic        busy_q;
  logic [32:0] trial;
  logic [32:0] sub;

  assign trial  = {rem_q, quot_q[31]};
  assign sub    = trial - {1'b0, dvs_q};
  assign quot_o = quot_q;
  assign rem_o  = rem_q;
  assign done_o = busy_q && (cnt_q == 6'd32);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (done_o) begin
      busy_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 6'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      dvs_q  <= divisor_i;
    end else if (busy_q && !done_o) begin
      if (!sub[32]) begin
        rem_q  <= sub[31:0];
        quot_q <= {quot_q[30:0], 1'b1};
      end else begin
        rem_q  <= trial[31:0];
        quot_q <= {quot_q[30:0], 1'b0};
      end
    end
  end

endmodule

@@ hdl/la32_back.sv @@
// ----------------------------------------------------------------------------
// la32_back
// Execute side: register file reads, decode, ALU/multiply/divide, writeback.
// ----------------------------------------------------------------------------
module la32_back
  import la32_pkg::*;
#(
  parameter int unsigned RegCount = RegCountDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        q_valid_i,
  output logic        q_pop_o,
  input  item_t       q_item_i,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output result_t     res_o
);

  localparam int unsigned AW = $clog2(RegCount);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_RD1  = 7'b0000010,
    S_RD2  = 7'b0000100,
    S_EXEC = 7'b0001000,
    S_MUL  = 7'b0010000,
    S_DIV  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_e;

  state_e      state_q;
  item_t       it_q;
  logic [31:0] a_q, b_q, d_q, r4_q, pc_q;
  logic [RegCount-1:1] vld_q;
  result_t     res_q;
  logic [63:0] prod_q;
  logic        pend_q;
  logic [4:0]  ldst_q;
  logic [2:0]  lkind_q;
  logic        div_sgn_q, div_rem_q, div_na_q, div_nq_q;
  logic [4:0]  wb_rd_q;
  logic        mul_hi_q;

  // register file: one write port, one read port, two copies for two reads
  logic          rf_we;
  logic [AW-1:0] rf_waddr, rf_raddr0, rf_raddr1;
  logic [31:0]   rf_wdata, rf_rdata0, rf_rdata1;
  logic [4:0]    ra0_q, ra1_q, rdidx0, rdidx1;
  logic [4:0]    wr_idx;

  la32_ram #(.Width(32), .Depth(RegCount)) u_rf0 (
    .clk_i, .we_i(rf_we), .waddr_i(rf_waddr), .wdata_i(rf_wdata),
    .raddr_i(rf_raddr0), .rdata_o(rf_rdata0)
  );
  la32_ram #(.Width(32), .Depth(RegCount)) u_rf1 (
    .clk_i, .we_i(rf_we), .waddr_i(rf_waddr), .wdata_i(rf_wdata),
    .raddr_i(rf_raddr1), .rdata_o(rf_rdata1)
  );

  assign rf_waddr  = wr_idx[AW-1:0];
  assign rf_raddr0 = rdidx0[AW-1:0];
  assign rf_raddr1 = rdidx1[AW-1:0];

  function automatic logic [31:0] rdval(input logic [4:0] idx, input logic [31:0] raw,
                                        input logic [RegCount-1:1] v);
    logic [31:0] r;
    r = 32'd0;
    if (idx != 5'd0 && 32'(idx) < RegCount && v[AW'(idx)]) r = raw;
    return r;
  endfunction

  // fields of the current word
  logic [31:0] w;
  logic [4:0]  rd, rj, rk;
  logic [11:0] imm12;
  logic [16:0] op17;
  logic [9:0]  op10;
  logic [5:0]  op6;
  assign w     = it_q.instr;
  assign rd    = w[4:0];
  assign rj    = w[9:5];
  assign rk    = w[14:10];
  assign imm12 = w[21:10];
  assign op17  = w[31:15];
  assign op10  = w[31:22];
  assign op6   = w[31:26];

  // read indices: IDLE presents rj/rk (captured in RD1), RD1 presents rd/r4 (captured in RD2)
  always_comb begin
    rdidx0 = ra0_q;
    rdidx1 = ra1_q;
    if (state_q == S_IDLE) begin
      rdidx0 = q_item_i.instr[9:5];
      rdidx1 = q_item_i.instr[14:10];
    end else if (state_q == S_RD1) begin
      rdidx0 = it_q.instr[4:0];
      rdidx1 = 5'd4;
    end
  end

  // divider
  logic        div_start, div_done;
  logic [31:0] div_q, div_r, div_a, div_b;
  la32_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(div_a), .divisor_i(div_b),
    .done_o(div_done), .quot_o(div_q), .rem_o(div_r)
  );

  logic signed_div;
  assign signed_div = (op17 == 17'h40) || (op17 == 17'h41);
  assign div_a = (signed_div && a_q[31]) ? 32'd0 - a_q : a_q;
  assign div_b = (signed_div && b_q[31]) ? 32'd0 - b_q : b_q;

  // execute decode
  logic        ex_we;
  logic [4:0]  ex_rd;
  logic [31:0] ex_val, ex_npc;
  result_t     ex_res;
  logic        ex_ld;
  logic [2:0]  ex_lk;
  logic        ex_mul, ex_div;
  logic [31:0] simm, off16, off26, sum_ai;

  assign simm   = {{20{imm12[11]}}, imm12};
  assign off16  = {{14{w[25]}}, w[25:10], 2'b00};
  assign off26  = {{4{w[9]}}, w[9:0], w[25:10], 2'b00};
  assign sum_ai = a_q + simm;

  always_comb begin
    ex_we  = 1'b0;
    ex_rd  = rd;
    ex_val = '0;
    ex_npc = pc_q + 32'd4;
    ex_res = '0;
    ex_ld  = 1'b0;
    ex_lk  = LK_W;
    ex_mul = 1'b0;
    ex_div = 1'b0;
    if (op17 >= 17'h20 && op17 <= 17'h43) begin
      ex_we = 1'b1;
      case (op17)
        17'h20: ex_val = a_q + b_q;
        17'h22: ex_val = a_q - b_q;
        17'h24: ex_val = {31'd0, $signed(a_q) < $signed(b_q)};
        17'h25: ex_val = {31'd0, a_q < b_q};
        17'h28: ex_val = ~(a_q | b_q);
        17'h29: ex_val = a_q & b_q;
        17'h2A: ex_val = a_q | b_q;
        17'h2B: ex_val = a_q ^ b_q;
        17'h2E: ex_val = a_q << b_q[4:0];
        17'h2F: ex_val = a_q >> b_q[4:0];
        17'h30: ex_val = 32'($signed(a_q) >>> b_q[4:0]);
        17'h38, 17'h39, 17'h3A: begin
          ex_we = 1'b0;
          ex_mul = 1'b1;
        end
        17'h40, 17'h41, 17'h42, 17'h43: begin
          ex_we = 1'b0;
          ex_div = 1'b1;
        end
        default: begin
          ex_we = 1'b0;
          ex_res.trap_code = TRAP_INVALID;
        end
      endcase
    end else if (op17 == 17'h54) begin
      ex_res.trap_code  = TRAP_BREAK;
      ex_res.trap_value = r4_q;
    end else if (op17 == 17'h56) begin
      ex_res.trap_code = TRAP_SYSCALL;
    end else if (op17 == 17'h81) begin
      ex_we = 1'b1; ex_val = a_q << rk;
    end else if (op17 == 17'h89) begin
      ex_we = 1'b1; ex_val = a_q >> rk;
    end else if (op17 == 17'h91) begin
      ex_we = 1'b1; ex_val = 32'($signed(a_q) >>> rk);
    end else if (w[31:25] == 7'h0A) begin
      ex_we = 1'b1; ex_val = {w[24:5], 12'd0};
    end else if (w[31:25] == 7'h0E) begin
      ex_we = 1'b1; ex_val = pc_q + {w[24:5], 12'd0};
    end else if (op10 == 10'h008) begin
      ex_we = 1'b1; ex_val = {31'd0, $signed(a_q) < $signed(simm)};
    end else if (op10 == 10'h009) begin
      ex_we = 1'b1; ex_val = {31'd0, a_q < simm};
    end else if (op10 == 10'h00A) begin
      ex_we = 1'b1; ex_val = sum_ai;
    end else if (op10 == 10'h00D) begin
      ex_we = 1'b1; ex_val = a_q & {20'd0, imm12};
    end else if (op10 == 10'h00E) begin
      ex_we = 1'b1; ex_val = a_q | {20'd0, imm12};
    end else if (op10 == 10'h00F) begin
      ex_we = 1'b1; ex_val = a_q ^ {20'd0, imm12};
    end else if (w[31:24] == 8'h04 && rj <= 5'd1) begin
      ex_res.trap_code = TRAP_PRIV;
    end else if (op10 == 10'h0A0 || op10 == 10'h0A1 || op10 == 10'h0A2 ||
                 op10 == 10'h0A8 || op10 == 10'h0A9) begin
      ex_res.mem_valid   = 1'b1;
      ex_res.mem_address = sum_ai;
      ex_ld = 1'b1;
      case (op10)
        10'h0A0: begin ex_res.mem_size = 2'd0; ex_lk = LK_B;  end
        10'h0A1: begin ex_res.mem_size = 2'd1; ex_lk = LK_H;  end
        10'h0A2: begin ex_res.mem_size = 2'd2; ex_lk = LK_W;  end
        10'h0A8: begin ex_res.mem_size = 2'd0; ex_lk = LK_BU; end
        default: begin ex_res.mem_size = 2'd1; ex_lk = LK_HU; end
      endcase
    end else if (op10 == 10'h0A4 || op10 == 10'h0A5 || op10 == 10'h0A6) begin
      ex_res.mem_valid   = 1'b1;
      ex_res.mem_write   = 1'b1;
      ex_res.mem_address = sum_ai;
      ex_res.mem_size    = op10[1:0];
      ex_res.store_data  = d_q;
    end else if (op6 >= 6'h13 && op6 <= 6'h1B) begin
      case (op6)
        6'h13: begin ex_npc = a_q + off16; ex_we = 1'b1; ex_val = pc_q + 32'd4; end
        6'h14: ex_npc = pc_q + off26;
        6'h15: begin
          ex_npc = pc_q + off26; ex_we = 1'b1; ex_rd = 5'd1; ex_val = pc_q + 32'd4;
        end
        6'h16: if (a_q == d_q) ex_npc = pc_q + off16;
        6'h17: if (a_q != d_q) ex_npc = pc_q + off16;
        6'h18: if ($signed(a_q) < $signed(d_q)) ex_npc = pc_q + off16;
        6'h19: if (!($signed(a_q) < $signed(d_q))) ex_npc = pc_q + off16;
        6'h1A: if (a_q < d_q) ex_npc = pc_q + off16;
        default: if (a_q >= d_q) ex_npc = pc_q + off16;
      endcase
    end else if (w == 32'h0648_2800 || w == 32'h0648_3000 || w == 32'h0648_3800 ||
                 (w & 32'hFFFF_8000) == 32'h0649_8000) begin
      ex_res.trap_code = TRAP_PRIV;
    end else begin
      ex_res.trap_code = TRAP_INVALID;
    end
    ex_res.next_pc = ex_npc;
  end

  // load return extension
  logic [31:0] ld_val;
  always_comb begin
    case (lkind_q)
      LK_B:    ld_val = {{24{it_q.load_data[7]}}, it_q.load_data[7:0]};
      LK_H:    ld_val = {{16{it_q.load_data[15]}}, it_q.load_data[15:0]};
      LK_BU:   ld_val = {24'd0, it_q.load_data[7:0]};
      LK_HU:   ld_val = {16'd0, it_q.load_data[15:0]};
      default: ld_val = it_q.load_data;
    endcase
  end

  // load return reports the current pc only
  result_t ret_res;
  always_comb begin
    ret_res         = '0;
    ret_res.next_pc = pc_q;
  end

  // divide/modulo results
  logic [31:0] div_res, quo_s, rem_s;
  assign quo_s = div_nq_q ? 32'd0 - div_q : div_q;
  assign rem_s = div_na_q ? 32'd0 - div_r : div_r;
  always_comb begin
    if (div_rem_q) div_res = (b_q == 32'd0) ? a_q : (div_sgn_q ? rem_s : div_r);
    else           div_res = (b_q == 32'd0) ? 32'd0 : (div_sgn_q ? quo_s : div_q);
  end

  // writeback select
  always_comb begin
    rf_we    = 1'b0;
    wr_idx   = ex_rd;
    rf_wdata = ex_val;
    if (state_q == S_EXEC) begin
      if (it_q.req_type) begin
        rf_we = pend_q; wr_idx = ldst_q; rf_wdata = ld_val;
      end else begin
        rf_we = ex_we;
      end
    end else if (state_q == S_MUL) begin
      rf_we = 1'b1; wr_idx = wb_rd_q;
      rf_wdata = mul_hi_q ? prod_q[63:32] : prod_q[31:0];
    end else if (state_q == S_DIV) begin
      rf_we = div_done; wr_idx = wb_rd_q; rf_wdata = div_res;
    end
    if (wr_idx == 5'd0 || 32'(wr_idx) >= RegCount) rf_we = 1'b0;
  end

  assign div_start   = (state_q == S_EXEC) && !it_q.req_type && ex_div;
  assign q_pop_o     = (state_q == S_IDLE) && q_valid_i;
  assign res_valid_o = (state_q == S_OUT);
  assign res_o       = res_q;

  logic signed [32:0] ma, mb;
  assign ma = {(op17 == 17'h39) && a_q[31], a_q};
  assign mb = {(op17 == 17'h39) && b_q[31], b_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pc_q    <= ResetPcDefault;
      pend_q  <= 1'b0;
      ldst_q  <= '0;
      lkind_q <= LK_B;
      vld_q   <= '0;
    end else begin
      if (cfg_we_i) pc_q <= cfg_wdata_i;
      if (rf_we) vld_q[AW'(wr_idx)] <= 1'b1;
      unique case (state_q)
        S_IDLE: if (q_valid_i) state_q <= S_RD1;
        S_RD1:  state_q <= S_RD2;
        S_RD2:  state_q <= S_EXEC;
        S_EXEC: begin
          if (it_q.req_type) begin
            pend_q  <= 1'b0;
            state_q <= S_OUT;
          end else begin
            pend_q <= ex_ld;
            pc_q   <= ex_npc;
            if (ex_ld) begin
              ldst_q  <= rd;
              lkind_q <= ex_lk;
            end
            state_q <= ex_mul ? S_MUL : (ex_div ? S_DIV : S_OUT);
          end
        end
        S_MUL:  state_q <= S_OUT;
        S_DIV:  if (div_done) state_q <= S_OUT;
        S_OUT:  if (res_ready_i) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      it_q <= q_item_i;
    end
    if (state_q == S_IDLE) begin
      ra0_q <= q_item_i.instr[9:5];
      ra1_q <= q_item_i.instr[14:10];
    end
    if (state_q == S_RD1) begin
      a_q <= rdval(ra0_q, rf_rdata0, vld_q);
      b_q <= rdval(ra1_q, rf_rdata1, vld_q);
    end
    if (state_q == S_RD2) begin
      d_q  <= rdval(it_q.instr[4:0], rf_rdata0, vld_q);
      r4_q <= rdval(5'd4, rf_rdata1, vld_q);
    end
    if (state_q == S_EXEC) begin
      res_q     <= it_q.req_type ? ret_res : ex_res;
      wb_rd_q   <= rd;
      mul_hi_q  <= (op17 != 17'h38);
      prod_q    <= 64'(ma * mb);
      div_sgn_q <= signed_div;
      div_rem_q <= (op17 == 17'h41) || (op17 == 17'h43);
      div_na_q  <= a_q[31];
      div_nq_q  <= a_q[31] ^ b_q[31];
    end
  end

endmodule

@@ tb/la32r_integer_decode_execute_unit_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// la32r_integer_decode_execute_unit_test
// Self-checking bench: directed table then random instruction mix, every
// result compared with an in-bench model of the decode/execute unit.
// ----------------------------------------------------------------------------
module la32r_integer_decode_execute_unit_test;
  import la32_pkg::*;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [31:0]  cfg_wdata_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [63:0]  s_axis_tdata = '0;   // instruction_word, load_data
  logic         s_axis_tuser = 1'b0; // req_type
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [135:0] m_axis_tdata;        // next_pc .. trap_value

  la32r_integer_decode_execute_unit DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always #5 clk_i = ~clk_i;

  typedef struct packed {
    logic [31:0] trap_value;
    logic [2:0]  trap_code;
    logic [31:0] store_data;
    logic [1:0]  mem_size;
    logic [31:0] mem_address;
    logic        mem_write;
    logic        mem_valid;
    logic [31:0] next_pc;
  } outcome_t;

  typedef struct {
    logic        is_load_ret;
    logic [31:0] word;
    logic [31:0] data;
    logic        has_exp;
    outcome_t    exp;
  } row_t;

  // model state
  logic [31:0]  regs [32];
  logic [31:0]  pc_q;
  logic         ld_pend;
  logic [4:0]   ld_dest;
  load_kind_e   ld_kind;

  outcome_t     pending_q [$];
  int           errors = 0;
  int           mism = 0;
  bit           stim_done = 0;

  function automatic logic [31:0] rd_reg(logic [4:0] i);
    return (i == 0) ? 32'd0 : regs[i];
  endfunction

  function automatic void wr_reg(logic [4:0] i, logic [31:0] v);
    if (i != 0) regs[i] = v;
  endfunction

  function automatic logic [31:0] sdiv(logic [31:0] a, logic [31:0] b, bit rem);
    logic [31:0] ua, ub, q, r;
    ua = a[31] ? -a : a;
    ub = b[31] ? -b : b;
    if (b == 0) return rem ? a : 32'd0;
    q = ua / ub;
    r = ua % ub;
    if (rem) return a[31] ? -r : r;
    return (a[31] != b[31]) ? -q : q;
  endfunction

  function automatic outcome_t execute_item(logic lr, logic [31:0] w, logic [31:0] ld);
    outcome_t o;
    logic [31:0] pc, npc, a, b, dv, simm, off16, off26, d;
    logic [4:0] rd, rj, rk;
    logic [16:0] op17;
    logic [9:0] op10;
    logic [5:0] op6;
    logic [63:0] p;
    o = '0;
    if (lr) begin
      if (ld_pend) begin
        case (ld_kind)
          LK_B:  d = {{24{ld[7]}}, ld[7:0]};
          LK_H:  d = {{16{ld[15]}}, ld[15:0]};
          LK_BU: d = {24'd0, ld[7:0]};
          LK_HU: d = {16'd0, ld[15:0]};
          default: d = ld;
        endcase
        wr_reg(ld_dest, d);
        ld_pend = 0;
      end
      o.next_pc = pc_q;
      return o;
    end
    ld_pend = 0;
    pc = pc_q;
    npc = pc + 4;
    rd = w[4:0]; rj = w[9:5]; rk = w[14:10];
    a = rd_reg(rj); b = rd_reg(rk); dv = rd_reg(rd);
    simm = {{20{w[21]}}, w[21:10]};
    op17 = w[31:15]; op10 = w[31:22]; op6 = w[31:26];
    o.trap_code = TRAP_NONE;
    if (op17 >= 17'h20 && op17 <= 17'h43) begin
      case (op17)
        17'h20: wr_reg(rd, a + b);
        17'h22: wr_reg(rd, a - b);
        17'h24: wr_reg(rd, {31'd0, $signed(a) < $signed(b)});
        17'h25: wr_reg(rd, {31'd0, a < b});
        17'h28: wr_reg(rd, ~(a | b));
        17'h29: wr_reg(rd, a & b);
        17'h2A: wr_reg(rd, a | b);
        17'h2B: wr_reg(rd, a ^ b);
        17'h2E: wr_reg(rd, a << b[4:0]);
        17'h2F: wr_reg(rd, a >> b[4:0]);
        17'h30: wr_reg(rd, $signed(a) >>> b[4:0]);
        17'h38: wr_reg(rd, a * b);
        17'h39: begin
          p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
          wr_reg(rd, p[63:32]);
        end
        17'h3A: begin
          p = {32'd0, a} * {32'd0, b};
          wr_reg(rd, p[63:32]);
        end
        17'h40: wr_reg(rd, sdiv(a, b, 0));
        17'h41: wr_reg(rd, sdiv(a, b, 1));
        17'h42: wr_reg(rd, b == 0 ? 32'd0 : a / b);
        17'h43: wr_reg(rd, b == 0 ? a : a % b);
        default: o.trap_code = TRAP_INVALID;
      endcase
    end else if (op17 == 17'h54) begin
      o.trap_code = TRAP_BREAK;
      o.trap_value = rd_reg(5'd4);
    end else if (op17 == 17'h56) o.trap_code = TRAP_SYSCALL;
    else if (op17 == 17'h81) wr_reg(rd, a << rk);
    else if (op17 == 17'h89) wr_reg(rd, a >> rk);
    else if (op17 == 17'h91) wr_reg(rd, $signed(a) >>> rk);
    else if (w[31:25] == 7'h0A) wr_reg(rd, {w[24:5], 12'd0});
    else if (w[31:25] == 7'h0E) wr_reg(rd, pc + {w[24:5], 12'd0});
    else if (op10 == 10'h008) wr_reg(rd, {31'd0, $signed(a) < $signed(simm)});
    else if (op10 == 10'h009) wr_reg(rd, {31'd0, a < simm});
    else if (op10 == 10'h00A) wr_reg(rd, a + simm);
    else if (op10 == 10'h00D) wr_reg(rd, a & {20'd0, w[21:10]});
    else if (op10 == 10'h00E) wr_reg(rd, a | {20'd0, w[21:10]});
    else if (op10 == 10'h00F) wr_reg(rd, a ^ {20'd0, w[21:10]});
    else if (w[31:24] == 8'h04 && rj <= 1) o.trap_code = TRAP_PRIV;
    else if (op10 inside {10'h0A0, 10'h0A1, 10'h0A2, 10'h0A8, 10'h0A9}) begin
      o.mem_valid = 1'b1;
      o.mem_address = a + simm;
      case (op10)
        10'h0A0: begin o.mem_size = 2'd0; ld_kind = LK_B; end
        10'h0A1: begin o.mem_size = 2'd1; ld_kind = LK_H; end
        10'h0A2: begin o.mem_size = 2'd2; ld_kind = LK_W; end
        10'h0A8: begin o.mem_size = 2'd0; ld_kind = LK_BU; end
        default: begin o.mem_size = 2'd1; ld_kind = LK_HU; end
      endcase
      ld_dest = rd;
      ld_pend = 1'b1;
    end else if (op10 inside {10'h0A4, 10'h0A5, 10'h0A6}) begin
      o.mem_valid = 1'b1;
      o.mem_write = 1'b1;
      o.mem_address = a + simm;
      o.mem_size = op10[1:0];
      o.store_data = dv;
    end else if (op6 >= 6'h13 && op6 <= 6'h1B) begin
      off16 = {{14{w[25]}}, w[25:10], 2'b00};
      off26 = {{4{w[9]}}, w[9:0], w[25:10], 2'b00};
      case (op6)
        6'h13: begin npc = a + off16; wr_reg(rd, pc + 4); end
        6'h14: npc = pc + off26;
        6'h15: begin npc = pc + off26; wr_reg(5'd1, pc + 4); end
        6'h16: if (a == dv) npc = pc + off16;
        6'h17: if (a != dv) npc = pc + off16;
        6'h18: if ($signed(a) < $signed(dv)) npc = pc + off16;
        6'h19: if (!($signed(a) < $signed(dv))) npc = pc + off16;
        6'h1A: if (a < dv) npc = pc + off16;
        default: if (a >= dv) npc = pc + off16;
      endcase
    end else if (w == 32'h0648_2800 || w == 32'h0648_3000 || w == 32'h0648_3800 ||
                 (w & 32'hFFFF_8000) == 32'h0649_8000)
      o.trap_code = TRAP_PRIV;
    else o.trap_code = TRAP_INVALID;
    pc_q = npc;
    o.next_pc = npc;
    return o;
  endfunction

  task automatic write_reset_pc(logic [31:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    pc_q = v;
  endtask

  // one transfer on the slave side, with a random gap first
  task automatic send_item(logic lr, logic [31:0] w, logic [31:0] ld, bit has_exp,
                           outcome_t exp);
    outcome_t o;
    int gap;
    gap = $urandom_range(0, 7);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= lr;
    s_axis_tdata <= {ld, w};
    do @(posedge clk_i); while (!s_axis_tready);
    o = execute_item(lr, w, ld);
    if (has_exp && o !== exp) begin
      errors++;
      $display("table row expectation differs from model: %h vs %h", exp, o);
    end
    pending_q.push_back(o);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_word();
    logic [4:0] rd, rj, rk;
    logic [16:0] op;
    logic [31:0] w;
    rd = 5'($urandom); rj = 5'($urandom); rk = 5'($urandom);
    if ($urandom_range(0, 3) == 0) rj = 5'($urandom_range(0, 7));
    case ($urandom_range(0, 14))
      0, 1, 2: w = {17'($urandom_range(32'h20, 32'h43)), rk, rj, rd};
      3: begin
        case ($urandom_range(0, 2))
          0: op = 17'h81;
          1: op = 17'h89;
          default: op = 17'h91;
        endcase
        w = {op, rk, rj, rd};
      end
      4: w = {7'h0A | {6'd0, 1'($urandom_range(0, 1))} << 2, 20'($urandom), rd};
      5, 6: w = {10'($urandom_range(8, 15)), 12'($urandom), rj, rd};
      7, 8: w = {10'h0A0 | 10'($urandom_range(0, 9)), 12'($urandom), rj, rd};
      9, 10: w = {6'($urandom_range(6'h13, 6'h1B)), 16'($urandom), rj, rd};
      11: w = {17'($urandom_range(0, 1)) ? 17'h54 : 17'h56, 15'($urandom)};
      12: w = {8'h04, 14'($urandom), 5'($urandom_range(0, 2)), rd};
      13: w = $urandom_range(0, 3) == 0 ? 32'h0649_8000 | 15'($urandom) : 32'h0648_3000;
      default: w = $urandom;
    endcase
    return w;
  endfunction

  row_t table_rows [$];

  task automatic add_row(logic lr, logic [31:0] w, logic [31:0] ld, bit he,
                         outcome_t e);
    row_t r;
    r.is_load_ret = lr; r.word = w; r.data = ld; r.has_exp = he; r.exp = e;
    table_rows.push_back(r);
  endtask

  // result checking
  always @(posedge clk_i) begin
    outcome_t got, e;
    if (m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[134:0];
      if (pending_q.size() == 0) begin
        errors++;
        if (mism < 10) $display("unexpected result %h", got);
        mism++;
      end else begin
        e = pending_q.pop_front();
        if (got !== e) begin
          errors++;
          if (mism < 10)
            $display("mismatch: exp pc=%h mv=%b mw=%b ad=%h sz=%0d sd=%h tc=%0d tv=%h\n  got pc=%h mv=%b mw=%b ad=%h sz=%0d sd=%h tc=%0d tv=%h",
                     e.next_pc, e.mem_valid, e.mem_write, e.mem_address, e.mem_size,
                     e.store_data, e.trap_code, e.trap_value,
                     got.next_pc, got.mem_valid, got.mem_write, got.mem_address,
                     got.mem_size, got.store_data, got.trap_code, got.trap_value);
          mism++;
        end
      end
    end
  end

  // receiver stalls
  initial begin
    int n;
    forever begin
      n = $urandom_range(0, 7);
      if ($urandom_range(0, 3) == 0) n = 0;
      if (n != 0) begin
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
    end
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    outcome_t e;
    logic [31:0] w;
    logic [31:0] pcs [4];
    for (int i = 0; i < 32; i++) regs[i] = '0;
    pc_q = ResetPcDefault;
    ld_pend = 0; ld_dest = '0; ld_kind = LK_B;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed table
    e = '0; e.next_pc = ResetPcDefault;
    add_row(1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, e);   // load return with none pending
    e.next_pc = ResetPcDefault + 4; e.trap_code = TRAP_INVALID;
    add_row(0, 32'hFFFF_FFFF, 0, 1, e);
    e.next_pc = ResetPcDefault + 8; e.trap_code = TRAP_SYSCALL;
    add_row(0, 32'h002B_0000, 0, 1, e);
    e.next_pc = ResetPcDefault + 12; e.trap_code = TRAP_BREAK;
    add_row(0, 32'h002A_0000, 0, 1, e);
    e.next_pc = ResetPcDefault + 16; e.trap_code = TRAP_PRIV;
    add_row(0, 32'h0648_3800, 0, 1, e);
    add_row(0, 32'h1400_0004, 0, 0, e);                // lu12i r4 = 0
    add_row(0, 32'h15FF_FFE5, 0, 0, e);                // lu12i r5 = 0xFFFFF000
    add_row(0, 32'h0280_0006, 0, 0, e);                // r6 = 0
    add_row(0, 32'h02BF_FCA7, 0, 0, e);                // r7 = r5 - 1
    add_row(0, 32'h0020_1887, 0, 0, e);                // div.w r7 = r4 / r6 (r6 = 0)
    add_row(0, 32'h0020_9888, 0, 0, e);                // mod.w r4%r6
    add_row(0, 32'h1500_0009, 0, 0, e);                // r9 = 0x80000000
    add_row(0, 32'h02BF_FC0A, 0, 0, e);                // r10 = -1
    add_row(0, 32'h0020_290B, 0, 0, e);                // div.w r11 = r8 / -1
    add_row(0, 32'h0020_A90C, 0, 0, e);                // mod.w r12 = r8 % -1
    add_row(0, 32'h0017_A92D, 0, 0, e);                // srl r13 = r9 >> (r10 & 31)
    add_row(0, 32'h0018_292E, 0, 0, e);                // sra by 31
    add_row(0, 32'h0280_012F, 0, 0, e);                // r15 = r9 + 0 ... base
    add_row(0, 32'h2800_01F0, 0, 0, e);                // ld.b
    add_row(0, 32'h0, 32'h0000_0080, 0, e);
    add_row(1, 0, 32'h0000_0080, 0, e);
    add_row(0, 32'h2A40_01F1, 0, 0, e);                // ld.hu, then cancelled
    add_row(0, 32'h2980_01EA, 0, 0, e);                // st.w
    add_row(1, 0, 32'hFFFF_FFFF, 0, e);                // ignored
    add_row(0, 32'h5BFF_FD29, 0, 0, e);                // beq backwards
    add_row(0, 32'h4C00_0141, 0, 0, e);                // jirl
    foreach (table_rows[i])
      send_item(table_rows[i].is_load_ret, table_rows[i].word, table_rows[i].data,
                table_rows[i].has_exp, table_rows[i].exp);
    drain();

    pcs[0] = 32'h0000_0000; pcs[1] = 32'hFFFF_FFFC;
    pcs[2] = $urandom; pcs[3] = ResetPcDefault;
    for (int ph = 0; ph < 4; ph++) begin
      write_reset_pc(pcs[ph]);
      for (int n = 0; n < 375; n++) begin
        w = rand_word();
        send_item(0, w, 0, 0, e);
        if (ld_pend && $urandom_range(0, 4) != 0)
          send_item(1, 0, $urandom, 0, e);
        else if ($urandom_range(0, 30) == 0)
          send_item(1, 0, $urandom, 0, e);
      end
      drain();
    end
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/la32_pkg.sv
hdl/la32_ram.sv
hdl/la32_front.sv
hdl/la32_div.sv
hdl/la32_back.sv
hdl/la32r_integer_decode_execute_unit.sv
tb/la32r_integer_decode_execute_unit_test.sv
